// ----- hw/rtl/sart_pkg.sv -----
// Package for the sorted address range table: sizes, codes, entry layout and
// the command and status bundles between controller and datapath.
// No dependencies.
package sart_pkg;

  localparam int TableDepth = 256;
  localparam int AddrBits   = 64;
  localparam int ModBits    = 16;
  localparam int TagBits    = 32;
  localparam int IdxBits    = $clog2(TableDepth);
  localparam int CntBits    = $clog2(TableDepth + 1);
  localparam int RemBits    = 9;

  // Operation codes
  localparam logic [1:0] OpInsert  = 2'd0;
  localparam logic [1:0] OpRemove  = 2'd1;
  localparam logic [1:0] OpResolve = 2'd2;
  localparam logic [1:0] OpClear   = 2'd3;

  // Status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] stop;
    logic [ModBits-1:0]  owner;
    logic [TagBits-1:0]  tag;
  } entry_t;

  localparam int EntryBits = $bits(entry_t);

  // Datapath commands
  typedef enum logic [4:0] {
    CMD_NOP, CMD_LOAD, CMD_SRCH_INIT, CMD_SRCH_RD, CMD_SRCH_UPD,
    CMD_RES_RD, CMD_RES_SET, CMD_RES_ZERO, CMD_INS_REJ, CMD_SH_INIT,
    CMD_SH_RD, CMD_SH_WR, CMD_INS_WR, CMD_RM_INIT, CMD_RM_RD, CMD_RM_WR,
    CMD_RM_FIN, CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       srch_done;
    logic       lo_zero;
    logic       ins_bad;
    logic       ins_full;
    logic       mod_zero;
    logic       sh_done;
    logic       rm_done;
  } dp_status_t;

endpackage

// ----- hw/rtl/sorted_address_range_table_core.sv -----
// Sorted address range table: a 256-entry table of half-open ranges kept in
// start order. Resolve runs a binary search, one memory read per step, then
// one more read of the chosen entry. Insert searches the same way, then moves
// the entries above the slot; remove sweeps all entries; clear empties the
// table. The entry memory has a single read port. One request is in work at
// a time; a new request is taken while the last result waits, but its work
// starts only once that result beat is gone. Depends on sart_pkg, sart_ctrl,
// sart_datapath.
module sorted_address_range_table_core
  import sart_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [AddrBits-1:0] addr_or_start,
  input  logic [AddrBits-1:0] range_end,
  input  logic [ModBits-1:0]  module_id,
  input  logic [TagBits-1:0]  entry_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic                found,
  output logic [AddrBits-1:0] hit_start,
  output logic [AddrBits-1:0] hit_end,
  output logic [ModBits-1:0]  hit_module,
  output logic [TagBits-1:0]  hit_tag,
  output logic [RemBits-1:0]  removed_count
);

  cmd_t       cmd;
  dp_status_t stat;

  sart_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sart_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (operation),
    .addr_or_start(addr_or_start),
    .range_end    (range_end),
    .module_id    (module_id),
    .entry_tag    (entry_tag),
    .stat         (stat),
    .status       (status),
    .found        (found),
    .hit_start    (hit_start),
    .hit_end      (hit_end),
    .hit_module   (hit_module),
    .hit_tag      (hit_tag),
    .removed_count(removed_count)
  );

endmodule

// ----- hw/rtl/sart_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sart_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sart_datapath.sv -----
// Datapath: entry memory, search bounds, shift and compaction pointers,
// captured request and result registers. Depends on sart_pkg and sart_ram.
module sart_datapath
  import sart_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [1:0]          operation,
  input  logic [AddrBits-1:0] addr_or_start,
  input  logic [AddrBits-1:0] range_end,
  input  logic [ModBits-1:0]  module_id,
  input  logic [TagBits-1:0]  entry_tag,
  output dp_status_t          stat,
  output logic [1:0]          status,
  output logic                found,
  output logic [AddrBits-1:0] hit_start,
  output logic [AddrBits-1:0] hit_end,
  output logic [ModBits-1:0]  hit_module,
  output logic [TagBits-1:0]  hit_tag,
  output logic [RemBits-1:0]  removed_count
);

  logic [1:0]          op;
  logic [AddrBits-1:0] key;
  logic [AddrBits-1:0] stop;
  logic [ModBits-1:0]  owner;
  logic [TagBits-1:0]  tag;
  logic [CntBits-1:0]  count;
  logic [CntBits-1:0]  lo;
  logic [CntBits-1:0]  hi;
  logic [CntBits-1:0]  idx;
  logic [CntBits-1:0]  keep;
  logic [CntBits-1:0]  mid;
  logic [CntBits-1:0]  idx_m1;
  logic [CntBits-1:0]  lo_m1;
  logic                go_right;
  logic                ram_we;
  logic [IdxBits-1:0]  ram_waddr;
  logic [IdxBits-1:0]  ram_raddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;
  logic [EntryBits-1:0] rdata_raw;

  assign ram_rdata = entry_t'(rdata_raw);
  assign mid    = CntBits'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign idx_m1 = idx - CntBits'(1);
  assign lo_m1  = lo - CntBits'(1);

  // Upper bound for resolve, lower bound for insert
  assign go_right = (op == OpResolve) ? (ram_rdata.start <= key) : (ram_rdata.start < key);

  // Status to controller
  always_comb begin
    stat.op        = op;
    stat.srch_done = (lo == hi);
    stat.lo_zero   = (lo == '0);
    stat.ins_bad   = (stop <= key);
    stat.ins_full  = (count == CntBits'(TableDepth));
    stat.mod_zero  = (owner == '0);
    stat.sh_done   = (idx == lo);
    stat.rm_done   = (idx == count);
  end

  // Memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[IdxBits-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[IdxBits-1:0];
    unique case (cmd)
      CMD_SRCH_RD: ram_raddr = mid[IdxBits-1:0];
      CMD_RES_RD:  ram_raddr = lo_m1[IdxBits-1:0];  // last entry with start <= key
      CMD_SH_RD:   ram_raddr = idx_m1[IdxBits-1:0];
      CMD_SH_WR:   ram_we = 1'b1;
      CMD_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = lo[IdxBits-1:0];
        ram_wdata = '{start: key, stop: stop, owner: owner, tag: tag};
      end
      CMD_RM_WR: begin
        ram_we    = (ram_rdata.owner != owner);
        ram_waddr = keep[IdxBits-1:0];
      end
      default: ;
    endcase
  end

  sart_ram #(
    .Width(EntryBits),
    .Depth(TableDepth)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata_raw)
  );

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd)
        CMD_INS_WR: count <= count + CntBits'(1);
        CMD_RM_FIN: count <= keep;
        CMD_CLEAR:  count <= '0;
        default: ;
      endcase
    end
  end

  // Request, pointers and results
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op    <= operation;
        key   <= addr_or_start;
        stop  <= range_end;
        owner <= module_id;
        tag   <= entry_tag;
      end
      CMD_SRCH_INIT: begin
        lo <= '0;
        hi <= count;
      end
      CMD_SRCH_UPD: begin
        if (go_right) begin
          lo <= mid + CntBits'(1);
        end else begin
          hi <= mid;
        end
      end
      CMD_RES_RD: idx <= lo;
      CMD_SH_INIT: idx <= count;
      CMD_SH_WR: idx <= idx_m1;
      CMD_RM_INIT: begin
        idx  <= '0;
        keep <= '0;
      end
      CMD_RM_WR: begin
        idx <= idx + CntBits'(1);
        if (ram_rdata.owner != owner) begin
          keep <= keep + CntBits'(1);
        end
      end
      default: ;
    endcase

    case (cmd)
      CMD_RES_SET: begin
        status        <= StOk;
        found         <= (key < ram_rdata.stop);
        hit_start     <= ram_rdata.start;
        hit_end       <= ram_rdata.stop;
        hit_module    <= ram_rdata.owner;
        hit_tag       <= ram_rdata.tag;
        removed_count <= '0;
      end
      CMD_RES_ZERO, CMD_CLEAR, CMD_INS_WR, CMD_INS_REJ, CMD_RM_FIN: begin
        status        <= StOk;
        found         <= 1'b0;
        hit_start     <= '0;
        hit_end       <= '0;
        hit_module    <= '0;
        hit_tag       <= '0;
        removed_count <= '0;
        if (cmd == CMD_INS_REJ) begin
          status <= (stop <= key) ? StEmpty : StFull;
        end
        if (cmd == CMD_RM_FIN) begin
          removed_count <= RemBits'(count - keep);
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/sart_ctrl.sv -----
// Controller state machine: sequences search, shift, compaction and result
// beats by issuing datapath commands. Depends on sart_pkg.
module sart_ctrl
  import sart_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t stat,
  output cmd_t       cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DISPATCH = 12'b000000000010,
    S_SRCH_RD  = 12'b000000000100,
    S_SRCH_UPD = 12'b000000001000,
    S_RES_SET  = 12'b000000010000,
    S_SH_CHK   = 12'b000000100000,
    S_SH_RD    = 12'b000001000000,
    S_SH_WR    = 12'b000010000000,
    S_RM_CHK   = 12'b000100000000,
    S_RM_RD    = 12'b001000000000,
    S_RM_WR    = 12'b010000000000,
    S_SPARE    = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   emit;

  assign in_ready = (state == S_IDLE);

  // Next state and command
  always_comb begin
    state_next = state;
    cmd        = CMD_NOP;
    emit       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        // wait until the previous result beat is gone
        if (!out_valid || out_ready) begin
          unique case (stat.op)
            OpInsert: begin
              if (stat.ins_bad || stat.ins_full) begin
                cmd = CMD_INS_REJ; emit = 1'b1; state_next = S_IDLE;
              end else begin
                cmd = CMD_SRCH_INIT; state_next = S_SRCH_RD;
              end
            end
            OpResolve: begin
              cmd = CMD_SRCH_INIT; state_next = S_SRCH_RD;
            end
            OpRemove: begin
              if (stat.mod_zero) begin
                cmd = CMD_RES_ZERO; emit = 1'b1; state_next = S_IDLE;
              end else begin
                cmd = CMD_RM_INIT; state_next = S_RM_CHK;
              end
            end
            default: begin
              cmd = CMD_CLEAR; emit = 1'b1; state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        if (!stat.srch_done) begin
          cmd = CMD_SRCH_RD; state_next = S_SRCH_UPD;
        end else if (stat.op == OpInsert) begin
          cmd = CMD_SH_INIT; state_next = S_SH_CHK;
        end else if (stat.lo_zero) begin
          cmd = CMD_RES_ZERO; emit = 1'b1; state_next = S_IDLE;
        end else begin
          cmd = CMD_RES_RD; state_next = S_RES_SET;
        end
      end
      S_SRCH_UPD: begin
        cmd = CMD_SRCH_UPD; state_next = S_SRCH_RD;
      end
      S_RES_SET: begin
        cmd = CMD_RES_SET; emit = 1'b1; state_next = S_IDLE;
      end
      S_SH_CHK: begin
        if (stat.sh_done) begin
          cmd = CMD_INS_WR; emit = 1'b1; state_next = S_IDLE;
        end else begin
          cmd = CMD_SH_RD; state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd = CMD_SH_WR; state_next = S_SH_CHK;
      end
      S_RM_CHK: begin
        if (stat.rm_done) begin
          cmd = CMD_RM_FIN; emit = 1'b1; state_next = S_IDLE;
        end else begin
          cmd = CMD_RM_RD; state_next = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd = CMD_RM_WR; state_next = S_RM_CHK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = emit | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
